### sv/plcdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcdt_pkg
// Shared types and constants of the plc delay timer bank.
// ----------------------------------------------------------------------------
package plcdt_pkg;

  localparam int TIMERS_DEFAULT = 64;

  localparam int CMD_W       = 2;
  localparam int ID_W        = 6;
  localparam int DELAY_W     = 16;
  localparam int ELAPSED_W   = 16;
  localparam int COUNT_W     = 32;
  localparam int PRESET_W    = 26;   // 65535 * 1000 fits
  localparam int MS_PER_S    = 1000;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // s_tdata bit positions
  localparam int TD_ID_LO      = 0;
  localparam int TD_START      = 6;
  localparam int TD_DELAY_LO   = 7;
  localparam int TD_SECS       = 23;
  localparam int TD_ELAPSED_LO = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE    = 2'd0,
    CMD_ON_DELAY  = 2'd1,
    CMD_OFF_DELAY = 2'd2,
    CMD_PULSE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the accepted transaction
    logic rd;     // read timer count, form preset
    logic exec;   // apply the item and load the result register
  } ctrl_cmd_t;

endpackage

### sv/plcdt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcdt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module plcdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/plcdt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcdt_ctrl
// Sequencer of the timer bank: accept, read, execute, result handshake.
// ----------------------------------------------------------------------------
module plcdt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output plcdt_pkg::ctrl_cmd_t cmd
);
  import plcdt_pkg::*;

  state_t state, state_next;
  logic   out_valid, out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_READ;
      end
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_READ: cmd.rd = 1'b1;
      ST_EXEC: cmd.exec = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  assign m_tvalid = out_valid;

endmodule

### sv/plcdt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcdt_datapath
// Item register, timer count RAM, used and valid flags, timer arithmetic.
// ----------------------------------------------------------------------------
module plcdt_datapath #(
  parameter int TIMERS = plcdt_pkg::TIMERS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  plcdt_pkg::ctrl_cmd_t              cmd,
  input  logic [plcdt_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic [plcdt_pkg::CMD_W-1:0]       s_tuser,
  output logic [plcdt_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import plcdt_pkg::*;

  // only ids reachable through the id field get storage
  localparam int MAX_IDS = 1 << ID_W;
  localparam int SLOTS   = (TIMERS < MAX_IDS) ? TIMERS : MAX_IDS;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic signed [COUNT_W:0] COUNT_MAX = (COUNT_W+1)'(33'h0_7FFF_FFFF);

  // captured item
  cmd_t                 item_cmd;
  logic [ID_W-1:0]      item_id;
  logic                 item_start;
  logic [DELAY_W-1:0]   item_delay;
  logic                 item_secs;
  logic [ELAPSED_W-1:0] item_elapsed;

  logic [PRESET_W-1:0]  preset;
  logic [ELAPSED_W-1:0] cycle_delta;
  logic [SLOTS-1:0]     valid;
  logic [SLOTS-1:0]     used;
  logic                 timer_out;

  logic [IDX_W-1:0]          idx;
  logic                      in_range;
  logic [COUNT_W-1:0]        rd_data;
  logic signed [COUNT_W-1:0] count_now;
  logic signed [COUNT_W:0]   sum;
  logic signed [COUNT_W-1:0] sum_sat;
  logic signed [COUNT_W-1:0] diff;
  logic signed [COUNT_W-1:0] preset_s;
  logic signed [COUNT_W-1:0] count_new;
  logic                      res;
  logic                      wr_en;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd     <= cmd_t'(s_tuser);
      item_id      <= s_tdata[TD_ID_LO +: ID_W];
      item_start   <= s_tdata[TD_START];
      item_delay   <= s_tdata[TD_DELAY_LO +: DELAY_W];
      item_secs    <= s_tdata[TD_SECS];
      item_elapsed <= s_tdata[TD_ELAPSED_LO +: ELAPSED_W];
    end
    if (cmd.rd) begin
      preset <= item_secs ? PRESET_W'(PRESET_W'(item_delay) * PRESET_W'(MS_PER_S))
                          : PRESET_W'(item_delay);
    end
  end

  assign idx      = item_id[IDX_W-1:0];
  assign in_range = ({1'b0, item_id} < (ID_W+1)'(SLOTS));
  assign wr_en    = cmd.exec && (item_cmd != CMD_UPDATE) && in_range;

  plcdt_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (SLOTS)
  ) u_count_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx),
    .wdata (count_new),
    .re    (cmd.rd),
    .raddr (idx),
    .rdata (rd_data)
  );

  // an entry cleared by reset or a cycle update reads as zero
  assign count_now = valid[idx] ? $signed(rd_data) : '0;
  assign sum       = {count_now[COUNT_W-1], count_now} + $signed({17'b0, cycle_delta});
  assign sum_sat   = (sum > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0] : sum[COUNT_W-1:0];
  // only used while the count is positive, so it cannot wrap
  assign diff      = count_now - $signed({16'b0, cycle_delta});
  assign preset_s  = $signed({{(COUNT_W-PRESET_W){1'b0}}, preset});

  always_comb begin
    count_new = count_now;
    res       = 1'b0;
    case (item_cmd)
      CMD_OFF_DELAY: begin
        if (item_start) begin
          count_new = preset_s;
          res       = 1'b1;
        end else if (count_now > 0) begin
          count_new = diff;
          res       = 1'b1;
        end
      end
      CMD_ON_DELAY, CMD_PULSE: begin
        if (item_start) begin
          count_new = sum_sat;
          if (sum_sat >= preset_s) begin
            res = 1'b1;
            if (item_cmd == CMD_PULSE) count_new = '0;
          end
        end else begin
          count_new = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      used        <= '0;
      cycle_delta <= '0;
    end else if (cmd.exec) begin
      if (item_cmd == CMD_UPDATE) begin
        // timers not used since the last update lose their count
        valid       <= valid & used;
        used        <= '0;
        cycle_delta <= item_elapsed;
      end else if (in_range) begin
        valid[idx] <= 1'b1;
        used[idx]  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      timer_out <= (item_cmd != CMD_UPDATE) && in_range && res;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-1){1'b0}}, timer_out};

endmodule

### sv/plc_delay_timer_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_delay_timer_bank
// Bank of plc delay timers (on-delay, off-delay, one-shot) with cycle update.
// ----------------------------------------------------------------------------
// Each accepted transaction yields one result transaction. An item passes
// from acceptance to result through capture, count RAM read, and execute and
// write back, since the count RAM has a registered read; a new item is
// taken as soon as the previous one has executed, even while its result still
// waits in the output register, and execution waits only when that register is
// still full. A cycle update clears the counts of unused timers through
// per-timer valid flags, so no clearing pass is needed after reset. Timer ids
// at or above TIMERS (or above the id range) are ignored and return 0.
module plc_delay_timer_bank #(
  parameter int TIMERS = plcdt_pkg::TIMERS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // timer_id[5:0], start_req[6], delay[22:7], unit_seconds[23], elapsed_ms[39:24]
  input  logic [plcdt_pkg::IN_TDATA_W-1:0]  s_tdata,
  // command[1:0]
  input  logic [plcdt_pkg::CMD_W-1:0]       s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // timer_out[0], zero padding above
  output logic [plcdt_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import plcdt_pkg::*;

  ctrl_cmd_t cmd;

  plcdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  plcdt_datapath #(
    .TIMERS (TIMERS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata)
  );

`ifndef SYNTH
  a_accept_leaves_idle : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  a_exec_gives_result : assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> m_tvalid)
    else $error("executed item left no result");

  a_one_command : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.rd, cmd.exec}))
    else $error("more than one datapath command at once");

  a_read_after_load : assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.rd)
    else $error("count read did not follow acceptance");
`endif

endmodule

### verif/plc_delay_timer_bank_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_delay_timer_bank_test
// Self-checking testbench of the plc delay timer bank. A queue of timer and
// cycle update items is streamed into the block with random gaps. Each
// accepted transaction is run through a local model of the timer bank, and
// the timer output it predicts is compared with each result transaction.
// ----------------------------------------------------------------------------
module plc_delay_timer_bank_test;
  import plcdt_pkg::*;

  localparam int TIMERS = TIMERS_DEFAULT;

  typedef struct {
    cmd_t                 cmd;
    logic [ID_W-1:0]      id;
    logic                 start;
    logic [DELAY_W-1:0]   delay;
    logic                 secs;
    logic [ELAPSED_W-1:0] elapsed;
  } timer_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [CMD_W-1:0]       s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  timer_item_t pending_items[$];
  logic        timer_out_q[$];
  int          n_total = 0;
  int          n_accepted = 0;
  int          mismatches = 0;

  // model state of the bank
  int                 cycle_ms;
  logic signed [31:0] count_ms [TIMERS];
  logic               used [TIMERS];

  plc_delay_timer_bank #(
    .TIMERS(TIMERS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [31:0] clamp_ms(longint v);
    if (v > longint'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
    if (v < -longint'(64'h8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // updates the bank model and returns the expected timer output
  function automatic logic apply_timer_item(timer_item_t it);
    longint preset;
    logic   fired;
    int     i;
    fired = 1'b0;
    if (it.cmd == CMD_UPDATE) begin
      cycle_ms = int'(it.elapsed);
      for (i = 0; i < TIMERS; i++) begin
        if (!used[i]) count_ms[i] = '0;
        used[i] = 1'b0;
      end
      return 1'b0;
    end
    if (int'(it.id) >= TIMERS) return 1'b0;
    preset = it.secs ? longint'(it.delay) * longint'(MS_PER_S) : longint'(it.delay);
    if (it.cmd == CMD_OFF_DELAY) begin
      if (it.start) begin
        count_ms[it.id] = clamp_ms(preset);
        fired = 1'b1;
      end else if (count_ms[it.id] > 0) begin
        fired = 1'b1;
        count_ms[it.id] = clamp_ms(longint'(count_ms[it.id]) - longint'(cycle_ms));
      end
    end else if (it.start) begin
      count_ms[it.id] = clamp_ms(longint'(count_ms[it.id]) + longint'(cycle_ms));
      if (longint'(count_ms[it.id]) >= preset) begin
        fired = 1'b1;
        // one-shot restarts the count after firing
        if (it.cmd == CMD_PULSE) count_ms[it.id] = '0;
      end
    end else begin
      count_ms[it.id] = '0;
    end
    used[it.id] = 1'b1;
    return fired;
  endfunction

  task automatic push_item(cmd_t cmd, int id, logic start, int delay, logic secs,
                           int elapsed);
    timer_item_t it;
    it.cmd     = cmd;
    it.id      = id[ID_W-1:0];
    it.start   = start;
    it.delay   = delay[DELAY_W-1:0];
    it.secs    = secs;
    it.elapsed = elapsed[ELAPSED_W-1:0];
    pending_items.push_back(it);
  endtask

  // driver
  always @(posedge clk) begin
    timer_item_t it;
    int          gap_pct;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        it.cmd     = cmd_t'(s_tuser);
        it.id      = s_tdata[TD_ID_LO +: ID_W];
        it.start   = s_tdata[TD_START];
        it.delay   = s_tdata[TD_DELAY_LO +: DELAY_W];
        it.secs    = s_tdata[TD_SECS];
        it.elapsed = s_tdata[TD_ELAPSED_LO +: ELAPSED_W];
        timer_out_q.push_back(apply_timer_item(it));
        n_accepted++;
      end
      gap_pct = (n_accepted < n_total / 3) ? 20 : (n_accepted < 2 * n_total / 3) ? 60 : 0;
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= gap_pct) begin
          it = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {it.elapsed, it.secs, it.delay, it.start, it.id};
          s_tuser  <= it.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic exp_out;
    int   stall_pct;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (timer_out_q.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, m_tdata);
          mismatches++;
        end else begin
          exp_out = timer_out_q.pop_front();
          if (m_tdata !== {{(OUT_TDATA_W-1){1'b0}}, exp_out}) begin
            $display("%0t: timer_out mismatch, expected %h, actual %h",
                     $time, {{(OUT_TDATA_W-1){1'b0}}, exp_out}, m_tdata);
            mismatches++;
          end
        end
      end
      stall_pct = (n_accepted < n_total / 3) ? 60 : (n_accepted < 2 * n_total / 3) ? 20 : 0;
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int   i;
    cmd_t cmd;
    int   id;
    int   delay;
    logic secs;
    int   elapsed;

    cycle_ms = 0;
    for (i = 0; i < TIMERS; i++) begin
      count_ms[i] = '0;
      used[i]     = 1'b0;
    end

    // directed part
    push_item(CMD_ON_DELAY,   0, 1'b1,     0, 1'b0,     0);  // zero preset fires at once
    push_item(CMD_UPDATE,    63, 1'b1, 65535, 1'b1, 65535);  // ignored fields set
    push_item(CMD_ON_DELAY,   0, 1'b1, 65535, 1'b0,     0);
    push_item(CMD_ON_DELAY,   1, 1'b1, 65535, 1'b1,     0);  // largest preset in seconds
    push_item(CMD_OFF_DELAY, 63, 1'b1,     1, 1'b0,     0);
    push_item(CMD_UPDATE,     0, 1'b0,     0, 1'b0,    10);
    push_item(CMD_OFF_DELAY, 63, 1'b0,     1, 1'b0,     0);  // runs below zero
    push_item(CMD_OFF_DELAY, 63, 1'b0,     1, 1'b0,     0);
    push_item(CMD_PULSE,      2, 1'b1,    15, 1'b0,     0);
    push_item(CMD_PULSE,      2, 1'b1,    15, 1'b0,     0);
    push_item(CMD_PULSE,      2, 1'b1,    15, 1'b0,     0);
    push_item(CMD_ON_DELAY,   0, 1'b0,     0, 1'b0,     0);
    push_item(CMD_UPDATE,     0, 1'b0,     0, 1'b0,     5);  // timer 1 idle, gets cleared
    push_item(CMD_ON_DELAY,   1, 1'b1,     5, 1'b0,     0);
    push_item(CMD_ON_DELAY,  63, 1'b1,     0, 1'b1,     0);  // negative count vs zero preset
    push_item(CMD_OFF_DELAY,  3, 1'b1,     2, 1'b1,     0);
    push_item(CMD_UPDATE,     0, 1'b0,     0, 1'b0,     0);
    push_item(CMD_OFF_DELAY,  3, 1'b0,     2, 1'b1,     0);
    push_item(CMD_UPDATE,     0, 1'b0,     0, 1'b0,     0);
    push_item(CMD_UPDATE,     0, 1'b0,     0, 1'b0,     3);
    push_item(CMD_OFF_DELAY,  3, 1'b0,     2, 1'b1,     0);

    // random part, mostly a small pool of timers so that counts build up
    for (i = 0; i < 600; i++) begin
      case ($urandom_range(99) / 15)
        0:       cmd = CMD_UPDATE;
        1, 2:    cmd = CMD_OFF_DELAY;
        3, 4:    cmd = CMD_PULSE;
        default: cmd = CMD_ON_DELAY;
      endcase
      id = ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(TIMERS - 1);
      case ($urandom_range(19))
        0, 1, 2: begin
          delay = $urandom_range(65535);
          secs  = 1'($urandom_range(1));
        end
        3, 4, 5: begin
          delay = $urandom_range(3);
          secs  = 1'b1;
        end
        default: begin
          delay = $urandom_range(60);
          secs  = 1'b0;
        end
      endcase
      elapsed = ($urandom_range(4) == 0) ? $urandom_range(65535) : $urandom_range(20);
      push_item(cmd, id, ($urandom_range(3) != 0), delay, secs, elapsed);
    end
    n_total = pending_items.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (n_accepted == n_total);
    wait (timer_out_q.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && timer_out_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
sv/plcdt_pkg.sv
sv/plcdt_ram.sv
sv/plcdt_ctrl.sv
sv/plcdt_datapath.sv
sv/plc_delay_timer_bank.sv
verif/plc_delay_timer_bank_test.sv
